@@ rtl/core/fmet_pkg.sv @@
// ----------------------------------------------------------------------------
// Flow meter event tracker package
// Shared widths, codes, arithmetic constants and the rate unit handshake.
// ----------------------------------------------------------------------------
package fmet_pkg;

  // Field widths fixed by the interface.
  localparam int ACT_W    = 2;
  localparam int NOW_W    = 32;
  localparam int RATE_W   = 29;
  localparam int VOL_W    = 24;
  localparam int DUR_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Configuration register widths.
  localparam int TMO_W = 16;
  localparam int GAP_W = 16;
  localparam int PPL_W = 12;

  // Rate arithmetic: product of pulses per litre and gap, and the numerator.
  localparam int PROD_W = PPL_W + GAP_W;
  localparam int NUM_W  = 30;
  localparam logic [NUM_W-1:0]  RATE_NUM = 30'd1000000000;
  localparam logic [RATE_W-1:0] RATE_MAX = 29'd500000000;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_TICK        = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLR_FLAGS   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLR_METRICS = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PPL     = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd3000;
  localparam logic [GAP_W-1:0] MAX_GAP_RST = 16'd1000;
  localparam logic [PPL_W-1:0] PPL_RST     = 12'd450;

  // Request to the rate unit.
  typedef struct packed {
    logic             start;
    logic [PPL_W-1:0] ppl;
    logic [GAP_W-1:0] gap;
  } rate_req_t;

  // Response from the rate unit.
  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] rate;
  } rate_rsp_t;

endpackage

@@ rtl/core/fmet_rate_unit.sv @@
// ----------------------------------------------------------------------------
// Flow rate unit
// Shift-and-add multiply of pulses per litre by the edge gap, then a
// restoring division of 1e9 by that product, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fmet_rate_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  fmet_pkg::rate_req_t req,
  output fmet_pkg::rate_rsp_t rsp
);
  import fmet_pkg::*;

  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(GAP_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_MUL  = 3'b010,
    R_DIV  = 3'b100
  } rstate_t;

  rstate_t            state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PPL_W-1:0]   ppl_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  rem_r;
  logic [NUM_W-1:0]   quo_r;
  logic               done_r;
  logic [RATE_W-1:0]  rate_r;

  logic [PPL_W-1:0]   addend;
  logic [PPL_W:0]     mul_sum;
  logic [PROD_W-1:0]  mul_nxt;
  logic [PROD_W:0]    rem_sh;
  logic [PROD_W+1:0]  diff;
  logic               fits;
  logic [PROD_W-1:0]  rem_nxt;
  logic [NUM_W-1:0]   quo_nxt;
  logic               done_nxt;

  // Multiply step: add the multiplicand on the low bit, then shift right.
  assign addend  = prod_r[0] ? ppl_r : '0;
  assign mul_sum = {1'b0, prod_r[PROD_W-1:GAP_W]} + {1'b0, addend};
  assign mul_nxt = {mul_sum, prod_r[GAP_W-1:1]};

  // Division step: bring down one numerator bit and subtract where it fits.
  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, prod_r};
  assign fits    = ~diff[PROD_W+1];
  assign rem_nxt = fits ? diff[PROD_W-1:0] : rem_sh[PROD_W-1:0];
  assign quo_nxt = {quo_r[NUM_W-2:0], fits};

  // The answer is ready after the last divide step, or straight after the
  // multiply when the product is zero.
  assign done_nxt = ((state_r == R_MUL) && (cnt_r == MUL_LAST) && (mul_nxt == '0)) ||
                    ((state_r == R_DIV) && (cnt_r == DIV_LAST));

  // Sequencer for the multiply and divide passes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
      ppl_r   <= '0;
      prod_r  <= '0;
      rem_r   <= '0;
      quo_r   <= '0;
      rate_r  <= '0;
    end else begin
      done_r <= done_nxt;
      unique case (state_r)
        R_IDLE: begin
          if (req.start) begin
            ppl_r   <= req.ppl;
            prod_r  <= {{PPL_W{1'b0}}, req.gap};
            cnt_r   <= '0;
            state_r <= R_MUL;
          end
        end
        R_MUL: begin
          prod_r <= mul_nxt;
          if (cnt_r == MUL_LAST) begin
            cnt_r <= '0;
            if (mul_nxt == '0) begin
              // A zero divisor gives the saturated rate.
              rate_r  <= RATE_MAX;
              state_r <= R_IDLE;
            end else begin
              rem_r   <= '0;
              quo_r   <= RATE_NUM;
              state_r <= R_DIV;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        R_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) begin
            rate_r  <= (quo_nxt > NUM_W'(RATE_MAX)) ? RATE_MAX : quo_nxt[RATE_W-1:0];
            state_r <= R_IDLE;
          end
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.rate = rate_r;

endmodule

@@ rtl/core/flow_meter_event_tracker.sv @@
// ----------------------------------------------------------------------------
// Flow meter event tracker
// Tracks flow events from millisecond pin samples: pulse count, flow rate,
// sticky start and end flags and the duration of the last event.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  in_      input      in_valid/in_stall  action, pin level, timestamp
//  out_     output     out_valid/out_stall flags, rate, pulse count, duration
//  cfg_     input      cfg_valid/cfg_ready register index, write data
//
// Each item is captured, then a bit-serial pass over TIME_BITS bits forms the time
// differences and compares; a decision step and the result load follow. A rate update
// also waits for the rate unit to multiply and divide; a zero product skips the divide.
// Reset is synchronous and active low; it clears tracker state and loads register defaults.
// The input stalls while an item is in progress; a stalled result waits in the output
// register while the next item is taken in, and holds that item back before it finishes.
// ----------------------------------------------------------------------------
module flow_meter_event_tracker #(
  parameter int TIME_BITS   = 32,
  parameter int VOLUME_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fmet_pkg::ACT_W-1:0]      in_action,
  input  logic                            in_pin_level,
  input  logic [fmet_pkg::NOW_W-1:0]      in_now_ms,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_is_flowing,
  output logic                            out_event_started,
  output logic                            out_event_ended,
  output logic [fmet_pkg::RATE_W-1:0]     out_flow_rate_ulps,
  output logic [fmet_pkg::VOL_W-1:0]      out_volume_pulses,
  output logic [fmet_pkg::DUR_W-1:0]      out_duration_ms,
  // Configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fmet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmet_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import fmet_pkg::*;

  localparam int CNT_W = $clog2(TIME_BITS);
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(TIME_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_RATE   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t                 state_r;
  logic [CNT_W-1:0]       cnt_r;

  // Configuration registers.
  logic [TMO_W-1:0]       timeout_r;
  logic [GAP_W-1:0]       max_gap_r;
  logic [PPL_W-1:0]       ppl_r;

  // Tracker state.
  logic                   prev_level_r;
  logic                   active_r;
  logic [TIME_BITS-1:0]   last_edge_r;
  logic [TIME_BITS-1:0]   start_time_r;
  logic [VOLUME_BITS-1:0] pulse_total_r;
  logic [RATE_W-1:0]      rate_value_r;
  logic                   start_flag_r;
  logic                   end_flag_r;
  logic [TIME_BITS-1:0]   last_dur_r;

  // Captured item and serial working registers.
  logic [ACT_W-1:0]       action_r;
  logic                   level_r;
  logic [TIME_BITS-1:0]   now_r;
  logic [TIME_BITS-1:0]   now_sh_r;
  logic [TIME_BITS-1:0]   edge_sh_r;
  logic [TIME_BITS-1:0]   start_sh_r;
  logic [GAP_W-1:0]       gap_sh_r;
  logic [TMO_W-1:0]       tmo_sh_r;
  logic [TIME_BITS-1:0]   since_sh_r;
  logic [TIME_BITS-1:0]   dur_sh_r;
  logic                   b_since_r;
  logic                   b_gap_r;
  logic                   b_tmo_r;
  logic                   b_d1_r;
  logic                   b_d2_r;

  // Output register.
  logic                   out_valid_r;

  logic [63:0]            now_ext;
  logic [63:0]            dur_ext;
  logic [31:0]            vol_ext;
  logic                   s_bit, d1_bit, d2_bit;
  logic                   n_bit, e_bit, st_bit, g_bit, t_bit;
  logic                   b_since_nxt, b_gap_nxt, b_tmo_nxt, b_d1_nxt, b_d2_nxt;
  logic                   is_tick, rising, start_ev, edge_ev, upd_ev, end_ev;
  logic                   load_out;
  rate_req_t              rate_req;
  rate_rsp_t              rate_rsp;

  assign now_ext = 64'(in_now_ms);

  // One bit of each serial subtraction and compare.
  assign n_bit  = now_sh_r[0];
  assign e_bit  = edge_sh_r[0];
  assign st_bit = start_sh_r[0];
  assign g_bit  = gap_sh_r[0];
  assign t_bit  = tmo_sh_r[0];

  // Time since the last edge.
  assign s_bit       = n_bit ^ e_bit ^ b_since_r;
  assign b_since_nxt = (~n_bit & e_bit) | (~(n_bit ^ e_bit) & b_since_r);
  // Borrow of since minus gap: set at the end when since is below the gap.
  assign b_gap_nxt   = (~s_bit & g_bit) | (~(s_bit ^ g_bit) & b_gap_r);
  // Borrow of timeout minus since: set when since exceeds the timeout.
  assign b_tmo_nxt   = (~t_bit & s_bit) | (~(t_bit ^ s_bit) & b_tmo_r);
  // Event duration minus the timeout.
  assign d1_bit      = n_bit ^ st_bit ^ b_d1_r;
  assign b_d1_nxt    = (~n_bit & st_bit) | (~(n_bit ^ st_bit) & b_d1_r);
  assign d2_bit      = d1_bit ^ t_bit ^ b_d2_r;
  assign b_d2_nxt    = (~d1_bit & t_bit) | (~(d1_bit ^ t_bit) & b_d2_r);

  // Event decisions once the serial pass is complete.
  assign is_tick  = (action_r == ACT_TICK);
  assign rising   = level_r & ~prev_level_r;
  assign start_ev = is_tick & rising & ~active_r;
  assign edge_ev  = is_tick & rising & active_r;
  assign upd_ev   = edge_ev & b_gap_r;
  assign end_ev   = is_tick & ~rising & active_r & (level_r == prev_level_r) & b_tmo_r;

  // The result register frees when its transfer completes.
  assign load_out = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  assign rate_req.start = (state_r == S_DECIDE) && upd_ev;
  assign rate_req.ppl   = ppl_r;
  assign rate_req.gap   = since_sh_r[GAP_W-1:0];

  fmet_rate_unit u_rate (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rate_req),
    .rsp   (rate_rsp)
  );

  // Main sequencer, state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      timeout_r     <= TIMEOUT_RST;
      max_gap_r     <= MAX_GAP_RST;
      ppl_r         <= PPL_RST;
      prev_level_r  <= 1'b0;
      active_r      <= 1'b0;
      last_edge_r   <= '0;
      start_time_r  <= '0;
      pulse_total_r <= '0;
      rate_value_r  <= '0;
      start_flag_r  <= 1'b0;
      end_flag_r    <= 1'b0;
      last_dur_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // Configuration writes; unknown indexes are ignored.
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TIMEOUT: timeout_r <= cfg_data[TMO_W-1:0];
          REG_MAX_GAP: max_gap_r <= cfg_data[GAP_W-1:0];
          REG_PPL:     ppl_r     <= cfg_data[PPL_W-1:0];
          default: ;
        endcase
      end

      // A new result takes the register as the previous one leaves it.
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_r == SCAN_LAST) begin
            cnt_r   <= '0;
            state_r <= S_DECIDE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DECIDE: begin
          if (is_tick) begin
            prev_level_r <= level_r;
          end
          if (start_ev) begin
            pulse_total_r <= '0;
            start_time_r  <= now_r;
            last_edge_r   <= now_r;
            active_r      <= 1'b1;
            start_flag_r  <= 1'b1;
          end
          if (edge_ev) begin
            last_edge_r <= now_r;
          end
          if (upd_ev && (pulse_total_r != '1)) begin
            pulse_total_r <= pulse_total_r + 1'b1;
          end
          if (end_ev) begin
            active_r   <= 1'b0;
            end_flag_r <= 1'b1;
            last_dur_r <= dur_sh_r;
          end
          if (action_r == ACT_CLR_FLAGS) begin
            start_flag_r <= 1'b0;
            end_flag_r   <= 1'b0;
          end
          if (action_r == ACT_CLR_METRICS) begin
            pulse_total_r <= '0;
            rate_value_r  <= '0;
          end
          state_r <= upd_ev ? S_RATE : S_FINISH;
        end
        S_RATE: begin
          if (rate_rsp.done) begin
            rate_value_r <= rate_rsp.rate;
            state_r      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Item capture and the bit-serial datapath.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      action_r   <= in_action;
      level_r    <= in_pin_level;
      now_r      <= now_ext[TIME_BITS-1:0];
      now_sh_r   <= now_ext[TIME_BITS-1:0];
      edge_sh_r  <= last_edge_r;
      start_sh_r <= start_time_r;
      gap_sh_r   <= max_gap_r;
      tmo_sh_r   <= timeout_r;
      b_since_r  <= 1'b0;
      b_gap_r    <= 1'b0;
      b_tmo_r    <= 1'b0;
      b_d1_r     <= 1'b0;
      b_d2_r     <= 1'b0;
    end else if (state_r == S_SCAN) begin
      now_sh_r   <= now_sh_r >> 1;
      edge_sh_r  <= edge_sh_r >> 1;
      start_sh_r <= start_sh_r >> 1;
      gap_sh_r   <= gap_sh_r >> 1;
      tmo_sh_r   <= tmo_sh_r >> 1;
      since_sh_r <= {s_bit, since_sh_r[TIME_BITS-1:1]};
      dur_sh_r   <= {d2_bit, dur_sh_r[TIME_BITS-1:1]};
      b_since_r  <= b_since_nxt;
      b_gap_r    <= b_gap_nxt;
      b_tmo_r    <= b_tmo_nxt;
      b_d1_r     <= b_d1_nxt;
      b_d2_r     <= b_d2_nxt;
    end
  end

  assign dur_ext = 64'(last_dur_r);
  assign vol_ext = 32'(pulse_total_r);

  // Result payload, loaded with the state after the item.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_is_flowing     <= active_r;
      out_event_started  <= start_flag_r;
      out_event_ended    <= end_flag_r;
      out_flow_rate_ulps <= rate_value_r;
      out_volume_pulses  <= vol_ext[VOL_W-1:0];
      out_duration_ms    <= dur_ext[DUR_W-1:0];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  // The reported rate never exceeds the saturation limit.
  a_rate_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_flow_rate_ulps <= RATE_MAX))
    else $error("flow rate above saturation limit");

  // The rate unit answers only while the sequencer waits for it.
  a_rate_owner: assert property (@(posedge clk) disable iff (!rst_n)
    rate_rsp.done |-> (state_r == S_RATE))
    else $error("rate unit answered outside the rate wait");

  // A transferred result leaves the register empty unless a new one loads.
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && (state_r != S_FINISH)) |=> !out_valid_r)
    else $error("result repeated after its transfer");

endmodule

@@ dv/flow_meter_event_tracker_tb.sv @@
// ----------------------------------------------------------------------------
// Flow meter event tracker testbench
// Drives millisecond samples and clear commands into the tracker, predicts
// the flags, rate, pulse count and duration of every transfer in its own
// model of the meter, and compares each result field by field. Both channels
// idle and stall at random, and the registers are reloaded between phases.
// ----------------------------------------------------------------------------
module flow_meter_event_tracker_tb;

  import fmet_pkg::*;

  // Action and register codes that the package leaves unnamed.
  localparam logic [ACT_W-1:0]     ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE   = 2'd3;

  // Cycles without any transfer before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  // Settling time at the end, well above the slowest item.
  localparam int unsigned DRAIN_CYCLES   = 200;

  // One reading of the meter as reported on the result channel.
  typedef struct packed {
    logic              flowing;
    logic              started;
    logic              ended;
    logic [RATE_W-1:0] rate;
    logic [VOL_W-1:0]  pulses;
    logic [DUR_W-1:0]  dur;
  } reading_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [ACT_W-1:0]     in_action    = ACT_TICK;
  logic                 in_pin_level = 1'b0;
  logic [NOW_W-1:0]     in_now_ms    = '0;

  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic                 out_is_flowing;
  logic                 out_event_started;
  logic                 out_event_ended;
  logic [RATE_W-1:0]    out_flow_rate_ulps;
  logic [VOL_W-1:0]     out_volume_pulses;
  logic [DUR_W-1:0]     out_duration_ms;

  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_TIMEOUT;
  logic [CFG_DAT_W-1:0] cfg_data     = '0;

  // Meter model: registers and event state.
  logic [TMO_W-1:0]  timeout_cfg  = TIMEOUT_RST;
  logic [GAP_W-1:0]  gap_cfg      = MAX_GAP_RST;
  logic [PPL_W-1:0]  ppl_cfg      = PPL_RST;
  logic              prev_pin     = 1'b0;
  logic              flowing      = 1'b0;
  logic [31:0]       last_edge_ms = '0;
  logic [31:0]       start_ms     = '0;
  logic [VOL_W-1:0]  pulse_cnt    = '0;
  logic [RATE_W-1:0] rate_ulps    = '0;
  logic              started_flag = 1'b0;
  logic              ended_flag   = 1'b0;
  logic [31:0]       dur_ms       = '0;

  reading_t    pending_readings[$];
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  bit          calm         = 1'b0;

  flow_meter_event_tracker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_pin_level       (in_pin_level),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_flowing     (out_is_flowing),
    .out_event_started  (out_event_started),
    .out_event_ended    (out_event_ended),
    .out_flow_rate_ulps (out_flow_rate_ulps),
    .out_volume_pulses  (out_volume_pulses),
    .out_duration_ms    (out_duration_ms),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Flow rate in microlitres per second for a gap between rising edges.
  function automatic logic [RATE_W-1:0] rate_for_gap(logic [31:0] gap);
    logic [63:0] divisor;
    logic [63:0] quot;
    divisor = 64'(ppl_cfg) * 64'(gap);
    if (divisor == 64'd0) return RATE_MAX;
    quot = 64'(RATE_NUM) / divisor;
    if (quot > 64'(RATE_MAX)) return RATE_MAX;
    return quot[RATE_W-1:0];
  endfunction

  // Advance the meter model by one accepted item and queue the reading.
  function automatic void predict_reading(logic [ACT_W-1:0] act, logic pin,
                                          logic [31:0] now_ms);
    logic [31:0] since;
    reading_t    r;
    since = now_ms - last_edge_ms;
    case (act)
      ACT_TICK: begin
        if (pin && !prev_pin) begin
          if (!flowing) begin
            // A rising edge while idle opens an event.
            pulse_cnt    = '0;
            start_ms     = now_ms;
            last_edge_ms = now_ms;
            flowing      = 1'b1;
            started_flag = 1'b1;
          end else begin
            if (since < 32'(gap_cfg)) begin
              rate_ulps = rate_for_gap(since);
              if (pulse_cnt != '1) pulse_cnt = pulse_cnt + 1'b1;
            end
            last_edge_ms = now_ms;
          end
        end else if (flowing && pin == prev_pin && since > 32'(timeout_cfg)) begin
          // Quiet for longer than the timeout: the event closes.
          flowing    = 1'b0;
          ended_flag = 1'b1;
          dur_ms     = now_ms - start_ms - 32'(timeout_cfg);
        end
        prev_pin = pin;
      end
      ACT_CLR_FLAGS: begin
        started_flag = 1'b0;
        ended_flag   = 1'b0;
      end
      ACT_CLR_METRICS: begin
        pulse_cnt = '0;
        rate_ulps = '0;
      end
      default: ;
    endcase
    r.flowing = flowing;
    r.started = started_flag;
    r.ended   = ended_flag;
    r.rate    = rate_ulps;
    r.pulses  = pulse_cnt;
    r.dur     = dur_ms;
    pending_readings.push_back(r);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Present one item and hold it until the transfer happens.
  task automatic send_item(logic [ACT_W-1:0] act, logic pin, logic [31:0] now_ms);
    if (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_pin_level <= pin;
    in_now_ms    <= now_ms;
    do @(posedge clk); while (in_stall);
    predict_reading(act, pin, now_ms);
  endtask

  // Stop sending and wait until every expected reading has arrived.
  task automatic drain_readings();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // One register write; the caller lowers the valid after the last one.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TIMEOUT: timeout_cfg = data;
      REG_MAX_GAP: gap_cfg     = data;
      REG_PPL:     ppl_cfg     = data[PPL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] tmo, logic [15:0] gap, logic [15:0] ppl,
                           bit poke_unused);
    drain_readings();
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_MAX_GAP, gap);
    write_reg(REG_PPL, ppl);
    if (poke_unused) write_reg(REG_NONE, 16'hA5A5);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly pulse trains with small time steps, plus edges
  // and quiet spells placed on the gap and timeout limits, and some noise.
  task automatic run_flow_traffic(int unsigned n_items, int unsigned step_max);
    logic [31:0] t;
    logic        pin;
    int unsigned pick;
    t = $urandom();
    for (int unsigned i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      pin  = prev_pin;
      if (pick < 78) begin
        if ($urandom_range(0, 2) != 0) pin = !pin;
        t = t + $urandom_range(0, step_max);
        send_item(ACT_TICK, pin, t);
      end else if (pick < 84) begin
        // Rising edge just below or right on the gap limit.
        if (prev_pin) send_item(ACT_TICK, 1'b0, t);
        t = last_edge_ms + 32'(gap_cfg) - $urandom_range(0, 1);
        send_item(ACT_TICK, 1'b1, t);
      end else if (pick < 89) begin
        // Held level right on or just past the timeout.
        t = last_edge_ms + 32'(timeout_cfg) + $urandom_range(0, 1);
        send_item(ACT_TICK, pin, t);
      end else if (pick < 91) begin
        t = t + 32'(timeout_cfg) + $urandom_range(1, 1000);
        send_item(ACT_TICK, pin, t);
      end else if (pick < 93) begin
        t = $urandom();
        send_item(ACT_TICK, 1'($urandom_range(0, 1)), t);
      end else if (pick < 96) begin
        send_item(ACT_CLR_FLAGS, 1'($urandom_range(0, 1)), $urandom());
      end else if (pick < 99) begin
        send_item(ACT_CLR_METRICS, 1'($urandom_range(0, 1)), $urandom());
      end else begin
        send_item(ACT_UNUSED, 1'($urandom_range(0, 1)), $urandom());
      end
    end
  endtask

  // Default registers: one event with two pulses, commands and the close.
  task automatic test_reset_state();
    send_item(ACT_UNUSED, 1'b1, 32'hFFFF_FFFF);
    send_item(ACT_TICK, 1'b1, 32'd100);
    send_item(ACT_TICK, 1'b0, 32'd200);
    send_item(ACT_TICK, 1'b1, 32'd300);
    send_item(ACT_TICK, 1'b0, 32'd300);
    send_item(ACT_TICK, 1'b1, 32'd300);
    send_item(ACT_CLR_METRICS, 1'b0, 32'h8000_0001);
    send_item(ACT_CLR_FLAGS, 1'b0, 32'h0000_0000);
    send_item(ACT_TICK, 1'b1, 32'd3301);
  endtask

  // Timeout of one millisecond, widest gap, one pulse per litre; time wraps mid-event
  // and a backwards step makes the duration wrap too.
  task automatic test_time_wrap();
    configure(16'd1, 16'hFFFF, 16'd1, 1'b0);
    send_item(ACT_TICK, 1'b1, 32'hFFFF_FFF0);
    send_item(ACT_TICK, 1'b0, 32'hFFFF_FFF0);
    send_item(ACT_TICK, 1'b1, 32'd5);
    send_item(ACT_TICK, 1'b0, 32'd5);
    send_item(ACT_TICK, 1'b1, 32'd6);
    send_item(ACT_TICK, 1'b1, 32'd8);
    send_item(ACT_TICK, 1'b0, 32'd900);
    send_item(ACT_TICK, 1'b1, 32'd1000);
    send_item(ACT_TICK, 1'b1, 32'd500);
  endtask

  // Pulses per litre masked to zero, zero timeout, a write to the unused
  // index, and commands that must leave the pin history alone.
  task automatic test_zero_divisor();
    configure(16'd0, 16'd50, 16'hF000, 1'b1);
    send_item(ACT_CLR_FLAGS, 1'b0, 32'h7FFF_FFFF);
    send_item(ACT_TICK, 1'b1, 32'd2000);
    send_item(ACT_TICK, 1'b0, 32'd2000);
    send_item(ACT_TICK, 1'b1, 32'd2010);
    send_item(ACT_TICK, 1'b0, 32'd2010);
    send_item(ACT_TICK, 1'b1, 32'd2015);
    send_item(ACT_CLR_METRICS, 1'b0, 32'd0);
    send_item(ACT_UNUSED, 1'b0, 32'hFFFF_FFFF);
    send_item(ACT_TICK, 1'b1, 32'd2015);
    send_item(ACT_TICK, 1'b1, 32'd2016);
  endtask

  // Short timeouts and gaps so that many events open and close.
  task automatic test_pulse_trains();
    logic [15:0] gap;
    for (int k = 0; k < 3; k++) begin
      gap = 16'($urandom_range(2, 60));
      configure(16'($urandom_range(2, 80)), gap, 16'($urandom_range(1, 4095)), 1'b0);
      run_flow_traffic(220, gap / 2 + 1);
    end
  endtask

  task automatic test_default_meter();
    configure(TIMEOUT_RST, MAX_GAP_RST, 16'(PPL_RST), 1'b0);
    run_flow_traffic(220, 400);
  endtask

  // Back-to-back transfers on both channels.
  task automatic test_steady_stream();
    calm = 1'b1;
    configure(16'd30, 16'd20, 16'd450, 1'b0);
    run_flow_traffic(220, 10);
    calm = 1'b0;
  endtask

  task automatic test_extreme_settings();
    configure(16'hFFFF, 16'hFFFF, 16'h0FFF, 1'b0);
    run_flow_traffic(100, 20000);
    configure(16'd1, 16'd1, 16'd1, 1'b0);
    run_flow_traffic(100, 1);
  endtask

  // Random back-pressure on the result channel.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 19);
  end

  // Compare each result transfer with the oldest expected reading.
  always @(posedge clk) begin : check_readings
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: result with no reading expected, actual rate %0d count %0d",
                 $time, out_flow_rate_ulps, out_volume_pulses);
      end else begin
        want = pending_readings.pop_front();
        check_field("is_flowing", 32'(want.flowing), 32'(out_is_flowing));
        check_field("event_started", 32'(want.started), 32'(out_event_started));
        check_field("event_ended", 32'(want.ended), 32'(out_event_ended));
        check_field("flow_rate_ulps", 32'(want.rate), 32'(out_flow_rate_ulps));
        check_field("volume_pulses", 32'(want.pulses), 32'(out_volume_pulses));
        check_field("duration_ms", want.dur, out_duration_ms);
      end
    end
  end

  // Abandon the run when no transfer has happened for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_time_wrap();
    test_zero_divisor();
    test_pulse_trains();
    test_default_meter();
    test_steady_stream();
    test_extreme_settings();
    drain_readings();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/fmet_pkg.sv
rtl/core/fmet_rate_unit.sv
rtl/core/flow_meter_event_tracker.sv
dv/flow_meter_event_tracker_tb.sv
